/* rtl/stp_pkg.sv */
// Shared types, codes and coil tables for the stepper phase sequencer.
// No dependencies; used by stp_core, stepper_phase_sequencer and stp_checker.
package stp_pkg;

   localparam int unsigned CYCLES_W = 10;
   localparam int unsigned TICKS_W  = 16;
   localparam int unsigned INDEX_W  = 3;
   localparam int unsigned COILS_W  = 4;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned CSR_WDATA_W = 16;

   localparam logic [CYCLES_W-1:0] CYCLES_RESET = 10'd25;
   localparam logic [TICKS_W-1:0]  TICKS_RESET  = 16'd500;

   localparam logic [CSR_IDX_W-1:0] CSR_CYCLES_PER_RUN    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_PATTERN = 1'b1;

   localparam logic [INDEX_W-1:0] LAST_QUAD = 3'd3;
   localparam logic [INDEX_W-1:0] LAST_HALF = 3'd7;
   localparam logic [COILS_W-1:0] COILS_OFF = 4'h0;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_WAVE = 2'd1,
      MODE_FULL = 2'd2,
      MODE_HALF = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0] start_request;
      logic       stop_key;
   } req_type;

   typedef struct packed {
      logic [COILS_W-1:0] coils;
      logic               running;
   } rsp_type;

   typedef struct packed {
      logic [CYCLES_W-1:0] cycles_per_run;
      logic [TICKS_W-1:0]  ticks_per_pattern;
   } cfg_type;

   function automatic logic [COILS_W-1:0] pattern_of(mode_type mode,
                                                      logic [INDEX_W-1:0] idx);
      logic [COILS_W-1:0] pat;
      pat = COILS_OFF;
      case (mode)
         MODE_WAVE: begin
            case (idx[1:0])
               2'd0:    pat = 4'h1;
               2'd1:    pat = 4'h2;
               2'd2:    pat = 4'h4;
               default: pat = 4'h8;
            endcase
         end
         MODE_FULL: begin
            case (idx[1:0])
               2'd0:    pat = 4'h3;
               2'd1:    pat = 4'h6;
               2'd2:    pat = 4'hC;
               default: pat = 4'h9;
            endcase
         end
         MODE_HALF: begin
            case (idx)
               3'd0:    pat = 4'h1;
               3'd1:    pat = 4'h3;
               3'd2:    pat = 4'h2;
               3'd3:    pat = 4'h6;
               3'd4:    pat = 4'h4;
               3'd5:    pat = 4'hC;
               3'd6:    pat = 4'h8;
               default: pat = 4'h9;
            endcase
         end
         default:   pat = COILS_OFF;
      endcase
      return pat;
   endfunction

   function automatic logic [INDEX_W-1:0] last_index(mode_type mode);
      return (mode == MODE_HALF) ? LAST_HALF : LAST_QUAD;
   endfunction

endpackage

/* rtl/stepper_phase_sequencer.sv */
// Stepper phase sequencer: the result of an input transfer is registered in the
// output register (or the skid stage); throughput one tick transfer per cycle,
// limited only by the output register and its skid stage when the result side stalls.
// Synchronous active-high reset: motor idle, coils off, both result stages empty,
// cycles_per_run = 25, ticks_per_pattern = 500.
// Depends on stp_pkg and stp_core.
module stepper_phase_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   // tick channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  stp_pkg::req_type                  req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output stp_pkg::rsp_type                  rsp_data,
   // configuration writes
   input  logic                              csr_wr_en,
   input  logic [stp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [stp_pkg::CSR_WDATA_W-1:0]   csr_wdata
);

   // configuration registers
   stp_pkg::cfg_type cfg_ff;

   // output register and skid stage
   logic             out_valid_ff, out_valid_in;
   stp_pkg::rsp_type out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   stp_pkg::rsp_type skid_data_ff, skid_data_in;

   logic             req_take;
   logic             rsp_take;
   stp_pkg::rsp_type step_result;

   // Hold off new ticks only while the skid stage is occupied: the output
   // register can then still drain, so at most one result waits behind it.
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   stp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_take),
      .item    (req_data),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   // Write configuration; both indexes decode to a register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycles_per_run    <= stp_pkg::CYCLES_RESET;
         cfg_ff.ticks_per_pattern <= stp_pkg::TICKS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            stp_pkg::CSR_CYCLES_PER_RUN:
               cfg_ff.cycles_per_run <= csr_wdata[stp_pkg::CYCLES_W-1:0];
            stp_pkg::CSR_TICKS_PER_PATTERN:
               cfg_ff.ticks_per_pattern <= csr_wdata[stp_pkg::TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // Result staging: refill the output register from the skid stage first,
   // otherwise straight from the sequencer; park a new result in the skid
   // stage when the output register is full and stalled.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_take;
            out_data_in  = step_result;
         end
      end else if (req_take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* rtl/stp_core.sv */
// Sequencer state and per-tick update for the stepper phase sequencer.
// Depends on stp_pkg for the payload, configuration and mode types.
module stp_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  stp_pkg::req_type item,
   input  stp_pkg::cfg_type cfg,
   output stp_pkg::rsp_type result
);

   logic                          active_ff, active_in;
   stp_pkg::mode_type             mode_ff, mode_in;
   logic [stp_pkg::INDEX_W-1:0]   index_ff, index_in;
   logic [stp_pkg::CYCLES_W-1:0]  cycle_ff, cycle_in;
   logic [stp_pkg::TICKS_W-1:0]   hold_ff, hold_in;
   logic [stp_pkg::COILS_W-1:0]   coil_ff, coil_in;

   logic [stp_pkg::TICKS_W:0]     hold_plus;
   logic [stp_pkg::CYCLES_W:0]    cycle_plus;

   assign hold_plus  = {1'b0, hold_ff} + {{stp_pkg::TICKS_W{1'b0}}, 1'b1};
   assign cycle_plus = {1'b0, cycle_ff} + {{stp_pkg::CYCLES_W{1'b0}}, 1'b1};

   always_comb begin
      active_in = active_ff;
      mode_in   = mode_ff;
      index_in  = index_ff;
      cycle_in  = cycle_ff;
      hold_in   = hold_ff;
      coil_in   = coil_ff;
      if (active_ff) begin
         if (item.stop_key) begin
            // stop ends the run on this tick
            active_in = 1'b0;
            coil_in   = stp_pkg::COILS_OFF;
            hold_in   = '0;
         end else if (hold_plus >= {1'b0, cfg.ticks_per_pattern}) begin
            hold_in = '0;
            if (index_ff >= stp_pkg::last_index(mode_ff)) begin
               index_in = '0;
               if (cycle_plus >= {1'b0, cfg.cycles_per_run}) begin
                  cycle_in  = '0;
                  active_in = 1'b0;
                  coil_in   = stp_pkg::COILS_OFF;
               end else begin
                  cycle_in = cycle_plus[stp_pkg::CYCLES_W-1:0];
                  coil_in  = stp_pkg::pattern_of(mode_ff, '0);
               end
            end else begin
               index_in = index_ff + 3'd1;
               coil_in  = stp_pkg::pattern_of(mode_ff, index_ff + 3'd1);
            end
         end else begin
            hold_in = hold_plus[stp_pkg::TICKS_W-1:0];
         end
      end else if (!item.stop_key && item.start_request != stp_pkg::MODE_NONE) begin
         active_in = 1'b1;
         mode_in   = stp_pkg::mode_type'(item.start_request);
         index_in  = '0;
         cycle_in  = '0;
         hold_in   = '0;
         coil_in   = stp_pkg::pattern_of(stp_pkg::mode_type'(item.start_request), '0);
      end
   end

   assign result = '{coils: coil_in, running: active_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         mode_ff   <= stp_pkg::MODE_NONE;
         index_ff  <= '0;
         cycle_ff  <= '0;
         hold_ff   <= '0;
         coil_ff   <= stp_pkg::COILS_OFF;
      end else if (step_en) begin
         active_ff <= active_in;
         mode_ff   <= mode_in;
         index_ff  <= index_in;
         cycle_ff  <= cycle_in;
         hold_ff   <= hold_in;
         coil_ff   <= coil_in;
      end
   end

endmodule

/* rtl/stp_checker.sv */
// Port-level checks for the stepper phase sequencer, bound to its top level.
// Depends on stp_pkg and stepper_phase_sequencer.
module stp_port_checks (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input stp_pkg::rsp_type                  rsp_data
);

   // no result is offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // an idle motor has its coils off
   a_idle_coils_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.running) |-> (rsp_data.coils == stp_pkg::COILS_OFF))
      else $error("coils driven while not running");

   // a running motor always drives some winding
   a_run_coils_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.running) |-> (rsp_data.coils != stp_pkg::COILS_OFF))
      else $error("running with coils off");

   // ticks are held off only while results are backed up
   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("tick stalled with no result waiting");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind stepper_phase_sequencer stp_port_checks u_stp_port_checks (.*);
